FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while out of reset.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Property checked on every edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/lfys_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lfys_pkg;

    localparam int EPOCH_W    = 8;
    localparam int DIV_CNT_W  = 7;
    localparam logic [DIV_CNT_W-1:0] DIV_LONG  = 7'd64;
    localparam logic [DIV_CNT_W-1:0] DIV_SHORT = 7'd32;
    localparam int CFG_ADDR_W = 4;
    localparam int PC_W       = 5;
    localparam logic MODE_START = 1'b0;

    typedef enum logic [1:0] {
        REG_MULTIPLIER = 2'd0,
        REG_MODULUS    = 2'd1,
        REG_CELL_COUNT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] multiplier;
        logic [31:0] modulus;
        logic [12:0] cell_count;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NOP        = 5'd0,
        OP_TAKE       = 5'd1,
        OP_MUL_SEED   = 5'd2,
        OP_MUL_RAND   = 5'd3,
        OP_LOAD64     = 5'd4,
        OP_LOAD_SPAN  = 5'd5,
        OP_ITER       = 5'd6,
        OP_RAND_REM   = 5'd7,
        OP_RAND_LOW   = 5'd8,
        OP_SET_J      = 5'd9,
        OP_RD_POS     = 5'd10,
        OP_RD_J       = 5'd11,
        OP_CAP_B      = 5'd12,
        OP_WR_POS     = 5'd13,
        OP_WR_J       = 5'd14,
        OP_EMIT_OK    = 5'd15,
        OP_EMIT_ERR   = 5'd16,
        OP_START_DONE = 5'd17,
        OP_SWEEP      = 5'd18,
        OP_EPOCH_CLR  = 5'd19
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER      = 4'd0,
        C_ALWAYS     = 4'd1,
        C_NO_INPUT   = 4'd2,
        C_MODE_START = 4'd3,
        C_STEP_BAD   = 4'd4,
        C_MOD_ZERO   = 4'd5,
        C_DIV_BUSY   = 4'd6,
        C_OUT_BUSY   = 4'd7,
        C_SWEEP_BUSY = 4'd8,
        C_EPOCH_LIVE = 4'd9
    } cond_sel_t;

    typedef struct packed {
        op_t             op;
        cond_sel_t       wait_c;
        cond_sel_t       jump_c;
        logic [PC_W-1:0] target;
    } ctl_word_t;

    typedef struct packed {
        logic no_input;
        logic mode_start;
        logic step_bad;
        logic mod_zero;
        logic div_busy;
        logic out_busy;
        logic sweep_busy;
        logic epoch_live;
    } flags_t;

    // program addresses
    localparam logic [PC_W-1:0] PC_INIT_SWEEP  = 5'd0;
    localparam logic [PC_W-1:0] PC_IDLE        = 5'd1;
    localparam logic [PC_W-1:0] PC_CHECK       = 5'd2;
    localparam logic [PC_W-1:0] PC_STEP_MUL    = 5'd3;
    localparam logic [PC_W-1:0] PC_STEP_LOAD   = 5'd4;
    localparam logic [PC_W-1:0] PC_STEP_DIV    = 5'd5;
    localparam logic [PC_W-1:0] PC_STEP_REM    = 5'd6;
    localparam logic [PC_W-1:0] PC_STEP_LOW    = 5'd7;
    localparam logic [PC_W-1:0] PC_SPAN        = 5'd8;
    localparam logic [PC_W-1:0] PC_SPAN_DIV    = 5'd9;
    localparam logic [PC_W-1:0] PC_SET_J       = 5'd10;
    localparam logic [PC_W-1:0] PC_RD_POS      = 5'd11;
    localparam logic [PC_W-1:0] PC_RD_J        = 5'd12;
    localparam logic [PC_W-1:0] PC_CAP_B       = 5'd13;
    localparam logic [PC_W-1:0] PC_WR_POS      = 5'd14;
    localparam logic [PC_W-1:0] PC_WR_J        = 5'd15;
    localparam logic [PC_W-1:0] PC_EMIT_OK     = 5'd16;
    localparam logic [PC_W-1:0] PC_EMIT_ERR    = 5'd17;
    localparam logic [PC_W-1:0] PC_START       = 5'd18;
    localparam logic [PC_W-1:0] PC_START_LOAD  = 5'd19;
    localparam logic [PC_W-1:0] PC_START_DIV   = 5'd20;
    localparam logic [PC_W-1:0] PC_START_REM   = 5'd21;
    localparam logic [PC_W-1:0] PC_START_LOW   = 5'd22;
    localparam logic [PC_W-1:0] PC_EPOCH       = 5'd23;
    localparam logic [PC_W-1:0] PC_WRAP_SWEEP  = 5'd24;
    localparam logic [PC_W-1:0] PC_EPOCH_CLR   = 5'd25;
    localparam logic [PC_W-1:0] PC_START_EMIT  = 5'd26;
    localparam logic [PC_W-1:0] PC_LAST        = PC_START_EMIT;

    function automatic ctl_word_t mk(op_t op, cond_sel_t wc, cond_sel_t jc,
                                     logic [PC_W-1:0] tgt);
        ctl_word_t w;
        w.op     = op;
        w.wait_c = wc;
        w.jump_c = jc;
        w.target = tgt;
        return w;
    endfunction

    // Control store: wait_c holds the step, else jump_c picks target over pc+1.
    function automatic ctl_word_t ucode(logic [PC_W-1:0] pc);
        ctl_word_t w;
        case (pc)
            PC_INIT_SWEEP: w = mk(OP_SWEEP,      C_SWEEP_BUSY, C_ALWAYS,   PC_IDLE);
            PC_IDLE:       w = mk(OP_TAKE,       C_NO_INPUT,   C_MODE_START, PC_START);
            PC_CHECK:      w = mk(OP_NOP,        C_NEVER,      C_STEP_BAD, PC_EMIT_ERR);
            PC_STEP_MUL:   w = mk(OP_MUL_RAND,   C_NEVER,      C_NEVER,    PC_IDLE);
            PC_STEP_LOAD:  w = mk(OP_LOAD64,     C_NEVER,      C_MOD_ZERO, PC_STEP_LOW);
            PC_STEP_DIV:   w = mk(OP_ITER,       C_DIV_BUSY,   C_NEVER,    PC_IDLE);
            PC_STEP_REM:   w = mk(OP_RAND_REM,   C_NEVER,      C_ALWAYS,   PC_SPAN);
            PC_STEP_LOW:   w = mk(OP_RAND_LOW,   C_NEVER,      C_NEVER,    PC_IDLE);
            PC_SPAN:       w = mk(OP_LOAD_SPAN,  C_NEVER,      C_NEVER,    PC_IDLE);
            PC_SPAN_DIV:   w = mk(OP_ITER,       C_DIV_BUSY,   C_NEVER,    PC_IDLE);
            PC_SET_J:      w = mk(OP_SET_J,      C_NEVER,      C_NEVER,    PC_IDLE);
            PC_RD_POS:     w = mk(OP_RD_POS,     C_NEVER,      C_NEVER,    PC_IDLE);
            PC_RD_J:       w = mk(OP_RD_J,       C_NEVER,      C_NEVER,    PC_IDLE);
            PC_CAP_B:      w = mk(OP_CAP_B,      C_NEVER,      C_NEVER,    PC_IDLE);
            PC_WR_POS:     w = mk(OP_WR_POS,     C_NEVER,      C_NEVER,    PC_IDLE);
            PC_WR_J:       w = mk(OP_WR_J,       C_NEVER,      C_NEVER,    PC_IDLE);
            PC_EMIT_OK:    w = mk(OP_EMIT_OK,    C_OUT_BUSY,   C_ALWAYS,   PC_IDLE);
            PC_EMIT_ERR:   w = mk(OP_EMIT_ERR,   C_OUT_BUSY,   C_ALWAYS,   PC_IDLE);
            PC_START:      w = mk(OP_MUL_SEED,   C_NEVER,      C_NEVER,    PC_IDLE);
            PC_START_LOAD: w = mk(OP_LOAD64,     C_NEVER,      C_MOD_ZERO, PC_START_LOW);
            PC_START_DIV:  w = mk(OP_ITER,       C_DIV_BUSY,   C_NEVER,    PC_IDLE);
            PC_START_REM:  w = mk(OP_RAND_REM,   C_NEVER,      C_ALWAYS,   PC_EPOCH);
            PC_START_LOW:  w = mk(OP_RAND_LOW,   C_NEVER,      C_NEVER,    PC_IDLE);
            PC_EPOCH:      w = mk(OP_NOP,        C_NEVER,      C_EPOCH_LIVE, PC_START_EMIT);
            PC_WRAP_SWEEP: w = mk(OP_SWEEP,      C_SWEEP_BUSY, C_NEVER,    PC_IDLE);
            PC_EPOCH_CLR:  w = mk(OP_EPOCH_CLR,  C_NEVER,      C_NEVER,    PC_IDLE);
            PC_START_EMIT: w = mk(OP_START_DONE, C_OUT_BUSY,   C_ALWAYS,   PC_IDLE);
            default:       w = mk(OP_NOP,        C_NEVER,      C_ALWAYS,   PC_IDLE);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/lfys_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lfys_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] seed;

    modport source (output valid, output mode, output seed, input ready);
    modport sink   (input valid, input mode, input seed, output ready);
endinterface

`default_nettype wire

FILE: rtl/lfys_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lfys_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] cell_index;
    logic        last;
    logic        status;

    modport source (output valid, output cell_index, output last, output status,
                    input ready);
    modport sink   (input valid, input cell_index, input last, input status,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/lcg_fisher_yates_shuffle_top.sv
// Emits a random permutation of 0..cell_count-1, one index per step item, by a
// forward Fisher-Yates shuffle driven by a Lehmer generator (r = multiplier*r mod
// modulus). A start item (mode 0) seeds the generator and returns a zero index;
// each step item (mode 1) returns the next index, last marks the final one, and a
// step with no running shuffle returns status 1. Every item yields one result.
// One item is in work at a time. A bit-serial remainder unit reduces the 64-bit
// product by the modulus for the generator, and the 32-bit random value into the
// remaining span; with modulus 0 the generator reduction is skipped and the low
// 32 bits of the product are used. The permutation lives in one RAM whose entries
// carry an epoch tag; after reset, and once every 255 starts, a sweep over all
// MAX_CELLS entries clears the tags and no item is taken then. Configuration
// registers (multiplier at 0x0, modulus at 0x4, cell_count at 0x8) are written
// over APB, by the user only while the block is idle; it does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module lcg_fisher_yates_shuffle_top #(
    parameter int MAX_CELLS = 4096
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lfys_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    lfys_in_if.sink                              cmd,
    lfys_out_if.source                           res
);

    logic [31:0] multiplier_reg;
    logic [31:0] modulus_reg;
    logic [12:0] cell_count_reg;
    logic        cfg_wr;

    lfys_pkg::reg_idx_t  reg_idx;
    lfys_pkg::cfg_t      cfg;
    lfys_pkg::ctl_word_t ctl;
    lfys_pkg::flags_t    flags;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = lfys_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            multiplier_reg <= 32'd16807;
            modulus_reg    <= 32'd2147483647;
            cell_count_reg <= 13'd64;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                lfys_pkg::REG_MULTIPLIER: multiplier_reg <= pwdata;
                lfys_pkg::REG_MODULUS:    modulus_reg    <= pwdata;
                lfys_pkg::REG_CELL_COUNT: cell_count_reg <= pwdata[12:0];
                default:                  multiplier_reg <= multiplier_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            lfys_pkg::REG_MULTIPLIER: prdata = multiplier_reg;
            lfys_pkg::REG_MODULUS:    prdata = modulus_reg;
            lfys_pkg::REG_CELL_COUNT: prdata = 32'(cell_count_reg);
            default:                  prdata = 32'd0;
        endcase
    end

    assign cfg.multiplier = multiplier_reg;
    assign cfg.modulus    = modulus_reg;
    assign cfg.cell_count = cell_count_reg;

    lfys_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctl   (ctl)
    );

    lfys_datapath #(
        .MAX_CELLS (MAX_CELLS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .ctl   (ctl),
        .flags (flags),
        .cmd   (cmd),
        .res   (res)
    );

endmodule

`default_nettype wire

FILE: rtl/lfys_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lfys_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/lfys_seq.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lfys_seq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lfys_pkg::flags_t    flags,
    output lfys_pkg::ctl_word_t      ctl
);

    logic [lfys_pkg::PC_W-1:0] pc_reg;
    logic [lfys_pkg::PC_W-1:0] pc_next;

    function automatic logic cond_hit(lfys_pkg::cond_sel_t sel, lfys_pkg::flags_t f);
        logic hit;
        case (sel)
            lfys_pkg::C_NEVER:      hit = 1'b0;
            lfys_pkg::C_ALWAYS:     hit = 1'b1;
            lfys_pkg::C_NO_INPUT:   hit = f.no_input;
            lfys_pkg::C_MODE_START: hit = f.mode_start;
            lfys_pkg::C_STEP_BAD:   hit = f.step_bad;
            lfys_pkg::C_MOD_ZERO:   hit = f.mod_zero;
            lfys_pkg::C_DIV_BUSY:   hit = f.div_busy;
            lfys_pkg::C_OUT_BUSY:   hit = f.out_busy;
            lfys_pkg::C_SWEEP_BUSY: hit = f.sweep_busy;
            lfys_pkg::C_EPOCH_LIVE: hit = f.epoch_live;
            default:                hit = 1'b0;
        endcase
        return hit;
    endfunction

    assign ctl = lfys_pkg::ucode(pc_reg);

    always_comb
    begin
        if (cond_hit(ctl.wait_c, flags))
        begin
            pc_next = pc_reg;
        end
        else if (cond_hit(ctl.jump_c, flags))
        begin
            pc_next = ctl.target;
        end
        else
        begin
            pc_next = pc_reg + lfys_pkg::PC_W'(1);
        end
    end

    // reset runs the tag clearing sweep before the first item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= lfys_pkg::PC_INIT_SWEEP;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    `ASSERT_CLK(a_pc_in_program, clk, (pc_reg <= lfys_pkg::PC_LAST), "pc left the program")

endmodule

`default_nettype wire

FILE: rtl/lfys_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lfys_datapath #(
    parameter int MAX_CELLS = 4096
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lfys_pkg::cfg_t      cfg,
    input  wire lfys_pkg::ctl_word_t ctl,
    output lfys_pkg::flags_t         flags,
    lfys_in_if.sink                  cmd,
    lfys_out_if.source               res
);

    localparam int IDX_W = $clog2(MAX_CELLS);
    localparam int CNT_W = $clog2(MAX_CELLS + 1);
    localparam int ENT_W = lfys_pkg::EPOCH_W + IDX_W;
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(MAX_CELLS - 1);

    // payload
    logic [31:0]                   seed_reg;
    logic [63:0]                   prod_reg;
    logic [31:0]                   rand_reg;
    logic [63:0]                   dvd_reg;
    logic [31:0]                   rem_reg;
    logic [31:0]                   dsr_reg;
    logic [lfys_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [IDX_W-1:0]              j_reg;
    logic [IDX_W-1:0]              a_reg;
    logic [IDX_W-1:0]              b_reg;
    logic [11:0]                   cell_index_reg;
    logic                          last_reg;
    logic                          status_reg;
    // control
    logic [CNT_W-1:0]              position_reg;
    logic                          active_reg;
    logic [lfys_pkg::EPOCH_W-1:0]  epoch_reg;
    logic [IDX_W-1:0]              sweep_reg;
    logic                          res_valid_reg;

    logic [31:0]      cc_raw;
    logic [31:0]      cc_eff;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] span;
    logic [CNT_W-1:0] j_sum;
    logic [IDX_W-1:0] pos_idx;
    logic             is_last;
    logic             out_free;
    logic             emit_go;
    logic [32:0]      shift_rem;
    logic [32:0]      trial;
    logic [31:0]      rem_iter;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;

    // an entry not tagged with the current epoch holds its own index
    function automatic logic [IDX_W-1:0] entry_val(logic [ENT_W-1:0] word,
                                                   logic [IDX_W-1:0] addr,
                                                   logic [lfys_pkg::EPOCH_W-1:0] ep);
        logic [IDX_W-1:0] v;
        if (word[ENT_W-1:IDX_W] == ep)
        begin
            v = word[IDX_W-1:0];
        end
        else
        begin
            v = addr;
        end
        return v;
    endfunction

    always_comb
    begin
        cc_raw = 32'(cfg.cell_count);
        cc_eff = cc_raw;
        if (cc_raw == 32'd0)
        begin
            cc_eff = 32'd1;
        end
        else if (cc_raw > 32'(MAX_CELLS))
        begin
            cc_eff = 32'(MAX_CELLS);
        end
    end

    assign count    = cc_eff[CNT_W-1:0];
    assign span     = count - position_reg;
    assign j_sum    = position_reg + rem_reg[CNT_W-1:0];
    assign pos_idx  = position_reg[IDX_W-1:0];
    assign is_last  = (position_reg == (count - CNT_W'(1)));
    assign out_free = !res_valid_reg || res.ready;
    assign emit_go  = out_free && (ctl.op inside {lfys_pkg::OP_EMIT_OK,
                                                  lfys_pkg::OP_EMIT_ERR,
                                                  lfys_pkg::OP_START_DONE});

    // one restoring remainder step
    assign shift_rem = {rem_reg, dvd_reg[63]};
    assign trial     = shift_rem - {1'b0, dsr_reg};
    assign rem_iter  = trial[32] ? shift_rem[31:0] : trial[31:0];

    assign cmd.ready = (ctl.op == lfys_pkg::OP_TAKE);

    assign flags.no_input   = !cmd.valid;
    assign flags.mode_start = (cmd.mode == lfys_pkg::MODE_START);
    assign flags.step_bad   = !active_reg || (position_reg >= count);
    assign flags.mod_zero   = (cfg.modulus == 32'd0);
    assign flags.div_busy   = (cnt_reg != lfys_pkg::DIV_CNT_W'(1));
    assign flags.out_busy   = !out_free;
    assign flags.sweep_busy = (sweep_reg != LAST_ADDR);
    assign flags.epoch_live = (epoch_reg != '1);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pos_idx;
        ram_wdata = {epoch_reg, b_reg};
        case (ctl.op)
            lfys_pkg::OP_WR_POS:
            begin
                ram_we = 1'b1;
            end
            lfys_pkg::OP_WR_J:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = {epoch_reg, a_reg};
            end
            lfys_pkg::OP_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                ram_wdata = '0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign ram_raddr = (ctl.op == lfys_pkg::OP_RD_J) ? j_reg : pos_idx;

    lfys_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_CELLS)
    ) u_perm_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            lfys_pkg::OP_TAKE:
            begin
                if (cmd.valid)
                begin
                    seed_reg <= cmd.seed;
                end
            end
            lfys_pkg::OP_MUL_SEED:  prod_reg <= 64'(cfg.multiplier) * 64'(seed_reg);
            lfys_pkg::OP_MUL_RAND:  prod_reg <= 64'(cfg.multiplier) * 64'(rand_reg);
            lfys_pkg::OP_LOAD64:
            begin
                dvd_reg <= prod_reg;
                dsr_reg <= cfg.modulus;
                rem_reg <= '0;
                cnt_reg <= lfys_pkg::DIV_LONG;
            end
            lfys_pkg::OP_LOAD_SPAN:
            begin
                dvd_reg <= {rand_reg, 32'd0};
                dsr_reg <= 32'(span);
                rem_reg <= '0;
                cnt_reg <= lfys_pkg::DIV_SHORT;
            end
            lfys_pkg::OP_ITER:
            begin
                rem_reg <= rem_iter;
                dvd_reg <= {dvd_reg[62:0], 1'b0};
                cnt_reg <= cnt_reg - lfys_pkg::DIV_CNT_W'(1);
            end
            lfys_pkg::OP_RAND_REM:  rand_reg <= rem_reg;
            lfys_pkg::OP_RAND_LOW:  rand_reg <= prod_reg[31:0];
            lfys_pkg::OP_SET_J:     j_reg    <= j_sum[IDX_W-1:0];
            lfys_pkg::OP_RD_J:      a_reg    <= entry_val(ram_rdata, pos_idx, epoch_reg);
            lfys_pkg::OP_CAP_B:     b_reg    <= entry_val(ram_rdata, j_reg, epoch_reg);
            default:
            begin
                rand_reg <= rand_reg;
            end
        endcase

        if (emit_go)
        begin
            cell_index_reg <= (ctl.op == lfys_pkg::OP_EMIT_OK) ? 12'(b_reg) : 12'd0;
            last_reg       <= (ctl.op == lfys_pkg::OP_EMIT_OK) && is_last;
            status_reg     <= (ctl.op == lfys_pkg::OP_EMIT_ERR);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg  <= '0;
            active_reg    <= 1'b0;
            epoch_reg     <= '0;
            sweep_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            case (ctl.op)
                lfys_pkg::OP_SWEEP:
                begin
                    sweep_reg <= (sweep_reg == LAST_ADDR) ? '0 : sweep_reg + IDX_W'(1);
                end
                lfys_pkg::OP_EPOCH_CLR:
                begin
                    // the old shuffle is gone once its tags are wiped
                    epoch_reg  <= '0;
                    active_reg <= 1'b0;
                end
                lfys_pkg::OP_START_DONE:
                begin
                    if (out_free)
                    begin
                        epoch_reg    <= epoch_reg + lfys_pkg::EPOCH_W'(1);
                        position_reg <= '0;
                        active_reg   <= 1'b1;
                    end
                end
                lfys_pkg::OP_EMIT_OK:
                begin
                    if (out_free)
                    begin
                        position_reg <= position_reg + CNT_W'(1);
                        if (is_last)
                        begin
                            active_reg <= 1'b0;
                        end
                    end
                end
                lfys_pkg::OP_EMIT_ERR:
                begin
                    if (out_free)
                    begin
                        active_reg <= 1'b0;
                    end
                end
                default:
                begin
                    active_reg <= active_reg;
                end
            endcase

            if (emit_go)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.cell_index = cell_index_reg;
    assign res.last       = last_reg;
    assign res.status     = status_reg;

    `ASSERT_RST(a_epoch_nonzero_active, clk, rst_n, (active_reg |-> (epoch_reg != '0)), "active shuffle with cleared epoch")
    `ASSERT_RST(a_rem_below_divisor, clk, rst_n, (((ctl.op == lfys_pkg::OP_RAND_REM) || (ctl.op == lfys_pkg::OP_SET_J)) |-> (rem_reg < dsr_reg)), "remainder not reduced")

endmodule

`default_nettype wire
